### sv/b64d_pkg.sv
// Package: shared types, constants and the alphabet decode function for the base64url decoder.
package b64d_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned GROUP_BITS          = 18;
   localparam int unsigned SEXTET_BITS         = 6;
   localparam int unsigned WORD_BITS           = 24;
   localparam int unsigned BYTE_BITS           = 8;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;

   localparam logic [5:0] LOWER_OFFSET = 6'd26;
   localparam logic [5:0] DIGIT_OFFSET = 6'd52;
   localparam logic [5:0] DASH_VALUE   = 6'd62;
   localparam logic [5:0] UNDER_VALUE  = 6'd63;

   // Byte counts a job may carry
   localparam logic [1:0] BYTES_NONE  = 2'd0;
   localparam logic [1:0] BYTES_ONE   = 2'd1;
   localparam logic [1:0] BYTES_TWO   = 2'd2;
   localparam logic [1:0] BYTES_THREE = 2'd3;

   typedef struct packed {
      logic                  valid;
      logic [SEXTET_BITS-1:0] value;
   } sextet_type;

   // Decoded bytes of one request, first byte in the top lane
   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [1:0]           count;
      logic                 final_flag;
   } job_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         s.value = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         s.value = 6'(c - CHAR_LOWER_A) + LOWER_OFFSET;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         s.value = 6'(c - CHAR_DIGIT_0) + DIGIT_OFFSET;
      end else if (c == CHAR_DASH) begin
         s.value = DASH_VALUE;
      end else if (c == CHAR_UNDER) begin
         s.value = UNDER_VALUE;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

### sv/b64d_if.sv
// Interfaces: request channel (characters) and response channel (decoded bytes).
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

### sv/b64d_front.sv
// Front end: classify characters, collect sextets and build byte jobs.
module b64d_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           char_code,
   input  logic                 end_of_text,
   output logic                 job_push,
   output b64d_pkg::job_type    job
);

   logic [b64d_pkg::GROUP_BITS-1:0] group_ff, group_in;
   logic [1:0]                      count_ff, count_in;
   b64d_pkg::sextet_type            sx;
   logic [b64d_pkg::GROUP_BITS-1:0] shifted;
   logic [b64d_pkg::GROUP_BITS-1:0] flush_bits;
   logic [1:0]                      flush_count;
   logic                            do_flush;

   assign sx      = b64d_pkg::sextet_of(char_code);
   assign shifted = {group_ff[b64d_pkg::GROUP_BITS-b64d_pkg::SEXTET_BITS-1:0], sx.value};

   always_comb begin
      group_in    = group_ff;
      count_in    = count_ff;
      flush_bits  = group_ff;
      flush_count = count_ff;
      do_flush    = 1'b0;
      job.word    = '0;
      job.count   = b64d_pkg::BYTES_NONE;
      job.final_flag = end_of_text;

      if (sx.valid && count_ff == 2'd3) begin
         job.word  = {group_ff, sx.value};
         job.count = b64d_pkg::BYTES_THREE;
         group_in  = '0;
         count_in  = '0;
      end else if (sx.valid) begin
         group_in    = shifted;
         count_in    = count_ff + 2'd1;
         flush_bits  = shifted;
         flush_count = count_ff + 2'd1;
         do_flush    = end_of_text;
      end else begin
         do_flush = end_of_text;
      end

      // Flush a partial group at end of string
      if (do_flush) begin
         group_in = '0;
         count_in = '0;
         case (flush_count)
            2'd2: begin
               job.word  = {flush_bits[11:4], 16'd0};
               job.count = b64d_pkg::BYTES_ONE;
            end
            2'd3: begin
               job.word  = {flush_bits[17:10], flush_bits[9:2], 8'd0};
               job.count = b64d_pkg::BYTES_TWO;
            end
            default: begin
               job.word  = '0;
               job.count = b64d_pkg::BYTES_NONE;
            end
         endcase
      end
   end

   assign job_push = accept && (job.count != b64d_pkg::BYTES_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         group_ff <= group_in;
         count_ff <= count_in;
      end
   end

endmodule

### sv/b64d_queue.sv
// Job queue between the front end and the byte sequencer.
module b64d_queue #(
   parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64d_pkg::job_type push_job,
   input  logic              pop,
   output b64d_pkg::job_type head_job,
   output logic              empty,
   output logic              full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   b64d_pkg::job_type  store [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign head_job = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### sv/b64d_back.sv
// Back end: emit the bytes of each job one per response.
module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  b64d_pkg::job_type head_job,
   input  logic              queue_empty,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_byte,
   output logic              out_final
);

   logic [b64d_pkg::WORD_BITS-1:0] word_ff, word_in;
   logic [1:0]                     left_ff, left_in;
   logic                           final_ff, final_in;
   logic                           taken;
   logic                           slot_free;

   assign out_valid = (left_ff != b64d_pkg::BYTES_NONE);
   assign out_byte  = word_ff[b64d_pkg::WORD_BITS-1 -: b64d_pkg::BYTE_BITS];
   assign out_final = final_ff && (left_ff == b64d_pkg::BYTES_ONE);
   assign taken     = out_valid && out_ready;
   assign slot_free = !out_valid || (taken && left_ff == b64d_pkg::BYTES_ONE);
   assign pop       = slot_free && !queue_empty;

   always_comb begin
      word_in  = word_ff;
      left_in  = left_ff;
      final_in = final_ff;
      if (pop) begin
         word_in  = head_job.word;
         left_in  = head_job.count;
         final_in = head_job.final_flag;
      end else if (taken) begin
         // Advance to the next byte of the job
         word_in = {word_ff[b64d_pkg::WORD_BITS-b64d_pkg::BYTE_BITS-1:0],
                    b64d_pkg::BYTE_BITS'(0)};
         left_in = left_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= b64d_pkg::BYTES_NONE;
      end else begin
         left_ff <= left_in;
      end
      word_ff  <= word_in;
      final_ff <= final_in;
   end

endmodule

### sv/base64url_decoder_unit.sv
// Top level: unpadded URL-safe base64 decoder, one character per request.
//
//   channel | role   | payload                       | handshake
//   req_ch  | sink   | char_code[7:0], end_of_text   | valid/ready
//   rsp_ch  | source | data_byte[7:0], final_byte    | valid/ready
//
// One character is accepted per cycle while the job queue has room; the front
// end decodes it and, when a group completes or the text ends, pushes a job of
// one to three bytes in the same cycle. The back end sends one byte per cycle
// while the response channel is ready; a full group of four characters yields three.
// Reset is synchronous and clears the group, the queue and the sequencer.
// A stalled response backs up into the queue; requests stall only when it is full.
module base64url_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   b64d_req_if.sink   req_ch,
   b64d_rsp_if.source rsp_ch
);

   logic              accept;
   logic              job_push;
   b64d_pkg::job_type job;
   b64d_pkg::job_type head_job;
   logic              queue_empty;
   logic              queue_full;
   logic              pop;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;

   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_ch.char_code),
      .end_of_text (req_ch.end_of_text),
      .job_push    (job_push),
      .job         (job)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (queue_empty),
      .pop         (pop),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_byte    (rsp_ch.data_byte),
      .out_final   (rsp_ch.final_byte)
   );

endmodule
